// File: rtl/mm4_pkg.sv
// mm4_pkg: shared types and constants for the 4x4 matrix multiplier.
// Used by every module under rtl/ except mm4_ram; depends on nothing.
package mm4_pkg;

  // Element and index widths (Q16.16 fixed point)
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 4;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int FRAC_BITS  = 16;

  // Queue depths
  localparam int TOKQ_DEPTH = 2;   // one token per loaded bank
  localparam int OUTQ_DEPTH = 4;   // result queue entries

  // Saturation limits
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Input item: one element of A and the same-index element of B
  typedef struct packed {
    logic signed [VAL_W-1:0] a_elem;
    logic signed [VAL_W-1:0] b_elem;
  } in_item_t;

  // Result item: one element of the product matrix
  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    logic [IDX_W-1:0]        out_index;
    logic                    out_last;
  } out_item_t;

  // Frame token: a fully loaded bank waiting for the compute side
  typedef struct packed {
    logic vld;
    logic bank;
  } tok_t;

endpackage

// File: rtl/mm4_ram.sv
// mm4_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mm4_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data_r
);

  logic [W-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

// File: rtl/mm4_tokq.sv
// mm4_tokq: two-entry queue of frame tokens between load and compute sides.
// Depends on mm4_pkg.
module mm4_tokq (
  input  logic          clk,
  input  logic          rst_n,
  input  mm4_pkg::tok_t tok_in,
  output logic          tokq_full,
  output mm4_pkg::tok_t tok_out,
  input  logic          tok_pop
);

  localparam int CNT_W = $clog2(mm4_pkg::TOKQ_DEPTH + 1);

  logic             bank_r [mm4_pkg::TOKQ_DEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign tokq_full     = (cnt_r == CNT_W'(mm4_pkg::TOKQ_DEPTH));
  assign tok_out.vld   = (cnt_r != '0);
  assign tok_out.bank  = bank_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (tok_in.vld) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (tok_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    cnt_nxt = cnt_r + CNT_W'(tok_in.vld) - CNT_W'(tok_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // token storage
  always_ff @(posedge clk) begin
    if (tok_in.vld) begin
      bank_r[wr_ptr_r] <= tok_in.bank;
    end
  end

  // a token never arrives while both banks are already queued
  assert property (@(posedge clk) disable iff (!rst_n)
    tok_in.vld |-> !tokq_full)
    else $error("token pushed into full queue");

  // compute side never retires a frame that was not queued
  assert property (@(posedge clk) disable iff (!rst_n)
    tok_pop |-> tok_out.vld)
    else $error("token popped from empty queue");

endmodule

// File: rtl/mm4_front.sv
// mm4_front: load side; writes input pairs into the current bank of the stores
// and queues a token when a frame is complete. Depends on mm4_pkg.
module mm4_front #(
  parameter int DIM   = 4,
  localparam int NELEM = DIM * DIM,
  localparam int AW    = $clog2(2 * NELEM)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  mm4_pkg::in_item_t        in_item,
  input  logic                     tokq_full,
  output mm4_pkg::tok_t            tok_wr,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [mm4_pkg::VAL_W-1:0] a_wr_data,
  output logic [mm4_pkg::VAL_W-1:0] b_wr_data
);

  localparam int CW = $clog2(NELEM);

  logic          accept;
  logic          frame_done;
  logic [CW-1:0] load_cnt_r, load_cnt_nxt;
  logic          bank_r, bank_nxt;

  // both banks busy while two frames wait for the compute side
  assign full       = tokq_full;
  assign accept     = push && !full;
  assign frame_done = accept && (load_cnt_r == CW'(NELEM - 1));

  // store write port
  assign wr_en     = accept;
  assign wr_addr   = AW'(bank_r) * AW'(NELEM) + AW'(load_cnt_r);
  assign a_wr_data = in_item.a_elem;
  assign b_wr_data = in_item.b_elem;

  // token for the bank just completed
  assign tok_wr.vld  = frame_done;
  assign tok_wr.bank = bank_r;

  // load counter and bank select
  always_comb begin
    load_cnt_nxt = load_cnt_r;
    bank_nxt     = bank_r;
    if (frame_done) begin
      load_cnt_nxt = '0;
      bank_nxt     = ~bank_r;
    end else if (accept) begin
      load_cnt_nxt = load_cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      bank_r     <= 1'b0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
      bank_r     <= bank_nxt;
    end
  end

  // load count wraps at the frame size, also for non-power-of-two sizes
  assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= CW'(NELEM - 1))
    else $error("load count past frame size");

endmodule

// File: rtl/mm4_back.sv
// mm4_back: compute side; one shared multiply-accumulate pipeline walks the
// product matrix and fills the result queue. Depends on mm4_pkg.
module mm4_back #(
  parameter int DIM   = 4,
  localparam int NELEM = DIM * DIM,
  localparam int AW    = $clog2(2 * NELEM)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mm4_pkg::tok_t             tok,
  output logic                      tok_pop,
  output logic [AW-1:0]             a_rd_addr,
  output logic [AW-1:0]             b_rd_addr,
  input  logic [mm4_pkg::VAL_W-1:0] a_rd_data,
  input  logic [mm4_pkg::VAL_W-1:0] b_rd_data,
  output logic                      empty,
  input  logic                      pop,
  output mm4_pkg::out_item_t        out_item
);

  localparam int KW    = $clog2(DIM);
  localparam int CW    = $clog2(NELEM);
  localparam int ACC_W = mm4_pkg::PROD_W + $clog2(DIM);
  localparam int CRW   = $clog2(mm4_pkg::OUTQ_DEPTH + 1);
  localparam int QPW   = $clog2(mm4_pkg::OUTQ_DEPTH);

  // issue stage counters
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] row_r, row_nxt;
  logic [KW-1:0] col_r, col_nxt;
  logic [CW-1:0] elem_r, elem_nxt;
  logic          k_max, row_max, col_max;
  logic          issue;
  logic          out_xfer;

  // pipeline stages
  logic          s1_vld_r, s1_first_r, s1_last_r;
  logic [CW-1:0] s1_idx_r;
  logic          s2_vld_r, s2_first_r, s2_last_r;
  logic [CW-1:0] s2_idx_r;
  logic signed [mm4_pkg::PROD_W-1:0] prod_nxt, prod_r;
  logic signed [ACC_W-1:0]           acc_nxt, acc_r, shifted;
  logic          s3_vld_r;
  logic [CW-1:0] s3_idx_r;

  // saturation
  logic [ACC_W-mm4_pkg::VAL_W:0] hi_bits;
  logic                          in_range;
  logic [mm4_pkg::VAL_W-1:0]     sat_val;

  // result queue and credit
  mm4_pkg::out_item_t oq_r [mm4_pkg::OUTQ_DEPTH];
  logic [QPW-1:0] oq_wr_r, oq_rd_r;
  logic [CRW-1:0] oq_cnt_r, oq_cnt_nxt;
  logic [CRW-1:0] credit_r, credit_nxt;
  logic           elem_start;

  assign k_max   = (k_r == KW'(DIM - 1));
  assign row_max = (row_r == KW'(DIM - 1));
  assign col_max = (col_r == KW'(DIM - 1));

  // an element starts only when the result queue has room reserved for it
  assign elem_start = tok.vld && (k_r == '0) && (credit_r < CRW'(mm4_pkg::OUTQ_DEPTH));
  assign issue      = elem_start || (tok.vld && (k_r != '0));
  assign tok_pop    = issue && k_max && row_max && col_max;
  assign out_xfer   = pop && !empty;

  // store read addresses: A(row, k) and B(k, col) of the queued bank
  assign a_rd_addr = AW'(tok.bank) * AW'(NELEM) + AW'(k_r) * AW'(DIM) + AW'(row_r);
  assign b_rd_addr = AW'(tok.bank) * AW'(NELEM) + AW'(col_r) * AW'(DIM) + AW'(k_r);

  // walk k inside row inside column
  always_comb begin
    k_nxt    = k_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    elem_nxt = elem_r;
    if (issue) begin
      if (!k_max) begin
        k_nxt = k_r + KW'(1);
      end else begin
        k_nxt = '0;
        if (tok_pop) begin
          elem_nxt = '0;
        end else begin
          elem_nxt = elem_r + CW'(1);
        end
        if (!row_max) begin
          row_nxt = row_r + KW'(1);
        end else begin
          row_nxt = '0;
          col_nxt = col_max ? '0 : col_r + KW'(1);
        end
      end
    end
  end

  // multiply and accumulate
  assign prod_nxt = $signed(a_rd_data) * $signed(b_rd_data);
  assign acc_nxt  = (s2_first_r ? ACC_W'(0) : acc_r) +
                    {{(ACC_W - mm4_pkg::PROD_W){prod_r[mm4_pkg::PROD_W-1]}}, prod_r};

  // floor shift and saturate to 32 bits
  assign shifted  = acc_r >>> mm4_pkg::FRAC_BITS;
  assign hi_bits  = shifted[ACC_W-1:mm4_pkg::VAL_W-1];
  assign in_range = (&hi_bits) || !(|hi_bits);
  assign sat_val  = in_range ? shifted[mm4_pkg::VAL_W-1:0] :
                    (shifted[ACC_W-1] ? mm4_pkg::VAL_MIN : mm4_pkg::VAL_MAX);

  // queue occupancy and reserved slots
  assign oq_cnt_nxt = oq_cnt_r + CRW'(s3_vld_r) - CRW'(out_xfer);
  assign credit_nxt = credit_r + CRW'(elem_start) - CRW'(out_xfer);
  assign empty      = (oq_cnt_r == '0);
  assign out_item   = oq_r[oq_rd_r];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r      <= '0;
      row_r    <= '0;
      col_r    <= '0;
      elem_r   <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
      credit_r <= '0;
    end else begin
      k_r      <= k_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      elem_r   <= elem_nxt;
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && s2_last_r;
      oq_cnt_r <= oq_cnt_nxt;
      credit_r <= credit_nxt;
      if (s3_vld_r) begin
        oq_wr_r <= oq_wr_r + QPW'(1);
      end
      if (out_xfer) begin
        oq_rd_r <= oq_rd_r + QPW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    s1_first_r <= (k_r == '0);
    s1_last_r  <= k_max;
    s1_idx_r   <= elem_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_idx_r   <= s1_idx_r;
    prod_r     <= prod_nxt;
    if (s2_vld_r) begin
      acc_r <= acc_nxt;
    end
    s3_idx_r <= s2_idx_r;
    if (s3_vld_r) begin
      oq_r[oq_wr_r].out_value <= sat_val;
      oq_r[oq_wr_r].out_index <= mm4_pkg::IDX_W'(s3_idx_r);
      oq_r[oq_wr_r].out_last  <= (s3_idx_r == CW'(NELEM - 1));
    end
  end

  // reserved slots always cover what sits in the queue
  assert property (@(posedge clk) disable iff (!rst_n)
    credit_r >= oq_cnt_r && credit_r <= CRW'(mm4_pkg::OUTQ_DEPTH))
    else $error("result credit out of step with queue");

  // a finished element always finds a free queue slot
  assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> (oq_cnt_r < CRW'(mm4_pkg::OUTQ_DEPTH)) || out_xfer)
    else $error("result queue overflow");

endmodule

// File: rtl/matrix4x4_multiply.sv
// matrix4x4_multiply: top level of the streaming DIM x DIM Q16.16 matrix multiplier.
// Depends on mm4_pkg, mm4_ram, mm4_front, mm4_tokq and mm4_back.
//
// Usage:
//   Input queue: drive in_item (a_elem, b_elem: element n of A and of B, column-major)
//   and raise push; the pair transfers on an edge with push high and full low.
//   DIM*DIM pairs form one frame. The stores are double banked, so a second frame
//   loads while the first is computed; full rises only when two loaded frames wait.
//   Result queue: while empty is low, out_item holds the oldest result (out_value,
//   out_index = column*DIM + row in its low 4 bits, out_last on the final element);
//   it transfers on an edge with pop high and empty low.
// Operation:
//   One multiply-accumulate unit forms every product of a frame in turn, while
//   the next frame loads into the other bank. With the compute side idle, the
//   first result of a frame reaches the ports through the store read, product,
//   accumulator and result queue registers.
//   The result queue holds 4 elements; when pop stays low the compute side
//   pauses at the next element boundary and loading continues until both banks
//   are full. Reset clears all control state; store contents need no clearing.
module matrix4x4_multiply #(
  parameter int DIM = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  mm4_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output mm4_pkg::out_item_t out_item
);

  localparam int NELEM = DIM * DIM;
  localparam int AW    = $clog2(2 * NELEM);

  logic                      tokq_full;
  logic                      tok_pop;
  mm4_pkg::tok_t             tok_wr;
  mm4_pkg::tok_t             tok_head;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [mm4_pkg::VAL_W-1:0] a_wr_data, b_wr_data;
  logic [AW-1:0]             a_rd_addr, b_rd_addr;
  logic [mm4_pkg::VAL_W-1:0] a_rd_data, b_rd_data;

  // load side
  mm4_front #(.DIM(DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .tokq_full (tokq_full),
    .tok_wr    (tok_wr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .a_wr_data (a_wr_data),
    .b_wr_data (b_wr_data)
  );

  // element stores, two banks each
  mm4_ram #(.W(mm4_pkg::VAL_W), .DEPTH(2 * NELEM)) u_a_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (a_wr_data),
    .rd_addr   (a_rd_addr),
    .rd_data_r (a_rd_data)
  );

  mm4_ram #(.W(mm4_pkg::VAL_W), .DEPTH(2 * NELEM)) u_b_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (b_wr_data),
    .rd_addr   (b_rd_addr),
    .rd_data_r (b_rd_data)
  );

  // frame tokens between the two sides
  mm4_tokq u_tokq (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_in    (tok_wr),
    .tokq_full (tokq_full),
    .tok_out   (tok_head),
    .tok_pop   (tok_pop)
  );

  // compute side
  mm4_back #(.DIM(DIM)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (tok_head),
    .tok_pop   (tok_pop),
    .a_rd_addr (a_rd_addr),
    .b_rd_addr (b_rd_addr),
    .a_rd_data (a_rd_data),
    .b_rd_data (b_rd_data),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

  // the last flag marks exactly the final storage index
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.out_last) |->
      (out_item.out_index == mm4_pkg::IDX_W'(NELEM - 1)))
    else $error("last flag on wrong element");

endmodule
